@@ rtl/core/distinct_row_biweight_average_macros.svh @@
// assertion helpers shared by the block's modules
`ifndef DISTINCT_ROW_BIWEIGHT_AVERAGE_MACROS_SVH
`define DISTINCT_ROW_BIWEIGHT_AVERAGE_MACROS_SVH

// condition holds at every clock edge out of reset
`define DRBA_ALWAYS(label, cond, msg) label: assert property (@(posedge clk) \
    disable iff (!rst_n) (cond)) else $error(msg);

// consequence holds in the same cycle as the antecedent
`define DRBA_IMPLIES(label, ante, cons, msg) label: assert property (@(posedge clk) \
    disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequence holds in the cycle after the antecedent
`define DRBA_NEXT(label, ante, cons, msg) label: assert property (@(posedge clk) \
    disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/drba_pkg.sv @@
`default_nettype none

package drba_pkg;

    // default capacities
    localparam int DEF_MAX_ROWS = 256;
    localparam int DEF_MAX_COLS = 32;

    // field and datapath widths
    localparam int DATA_W   = 64;
    localparam int CRC_W    = 32;
    localparam int POS_W    = 7;
    localparam int COLOUT_W = 6;
    localparam int STAT_W   = 2;
    localparam int DEN_W    = 67;
    localparam int FRAC_W   = 32;
    localparam int WGT_W    = 33;

    // arithmetic constants
    localparam logic [CRC_W-1:0]  CRC_POLY = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0]  CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [DATA_W-1:0] SIGN_BIT = 64'h8000_0000_0000_0000;
    localparam logic [DEN_W-1:0]  EPS_Q    = 67'd429497;
    localparam logic [WGT_W-1:0]  ONE_Q    = 33'h1_0000_0000;

    // action codes
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_FINISH = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK          = 2'd0,
        STAT_ZERO_WEIGHT = 2'd1,
        STAT_DROPPED     = 2'd2,
        STAT_NO_ROWS     = 2'd3
    } drba_status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_ROW_DONE,
        S_COL_START,
        S_LOAD_RD,
        S_LOAD_WR,
        S_SORT_WAIT,
        S_DEN,
        S_WGT_RD,
        S_WGT_CHK,
        S_WGT_DIV,
        S_WGT_SQR,
        S_WGT_TSQ,
        S_WGT_PLO,
        S_WGT_PHI,
        S_WGT_ACC,
        S_AVG_PREP,
        S_AVG_DIV,
        S_EMIT,
        S_EMPTY
    } drba_state_t;

    typedef enum logic [2:0] {
        SR_IDLE,
        SR_FIRST,
        SR_LOAD0,
        SR_WALK,
        SR_TAIL,
        SR_MED_A,
        SR_MED_B,
        SR_MED_C
    } drba_sort_state_t;

    // commands from the control to the sorter
    typedef struct packed {
        logic load_en;
        logic start;
    } drba_sort_cmd_t;

    // reflected crc-32 over 8 bytes, lsb first; collapses to an xor matrix
    function automatic logic [CRC_W-1:0] crc64_update(input logic [CRC_W-1:0] crc,
                                                      input logic [DATA_W-1:0] data);
        logic [CRC_W-1:0] c;
        c = crc;
        for (int k = 0; k < DATA_W; k++)
        begin
            c = (c >> 1) ^ ((c[0] ^ data[k]) ? CRC_POLY : '0);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/distinct_row_biweight_average.sv @@
// Robust per-column average over distinct rows of signed Q32.32 samples.
// Input channel (in_valid/in_stall): action 0 carries one element of the
// current row, row_end marks its last element; action 1 finishes the run.
// Elements other than a row end do not stall the input. A row end that is
// not short then compares the row's crc with every kept row, one checksum
// memory read at a time, and the input stalls until that scan is done.
// Finish walks the sample memory column by column. Per column with n kept
// rows: two loads and two bubble sorts in the scratch memory, a weight for
// each row whose deviation is under the scale (a 32-step divider and the
// multiplies), and a bit-serial final divide. The sort's scratch memory
// has a single read port.
// Output channel (out_valid/out_stall): one result item per column, last on
// the final one; a finish with no kept rows gives one item with status 3.
// A stalled result holds in the output register and the walk waits for it.
// Reset clears all control state and empties the output; the memories need
// no clearing, only entries already written are read.
`default_nettype none

`include "distinct_row_biweight_average_macros.svh"

module distinct_row_biweight_average #(
    parameter int MAX_ROWS = drba_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = drba_pkg::DEF_MAX_COLS
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic                                action,
    input  wire logic signed [drba_pkg::DATA_W-1:0]  sample,
    input  wire logic                                row_end,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic signed [drba_pkg::DATA_W-1:0]       average,
    output logic [drba_pkg::COLOUT_W-1:0]            column,
    output logic [drba_pkg::STAT_W-1:0]              status,
    output logic                                     last
);

    localparam int RK_W     = $clog2(MAX_ROWS + 1);
    localparam int ROW_AW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int ST_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int ST_AW    = (ST_DEPTH > 1) ? $clog2(ST_DEPTH) : 1;
    localparam int SW_W     = drba_pkg::WGT_W + RK_W;
    localparam int ACC_W    = 97 + RK_W;
    localparam int ACNT_W   = $clog2(ACC_W);
    localparam int DW       = drba_pkg::DATA_W;
    localparam int PW       = drba_pkg::POS_W;

    localparam logic [RK_W-1:0]  ROWS_CAP = RK_W'(MAX_ROWS);
    localparam logic [PW-1:0]    COLS_CAP = PW'(MAX_COLS);
    localparam logic [ST_AW-1:0] COLS_A   = ST_AW'(MAX_COLS);

    drba_pkg::drba_state_t state_reg, state_next;

    // run state
    logic [RK_W-1:0]               rows_kept_reg;
    logic [PW-1:0]                 row_length_reg;
    logic [PW-1:0]                 pos_reg;
    logic [drba_pkg::CRC_W-1:0]    crc_reg;
    logic                          dropped_reg;
    logic [drba_pkg::CRC_W-1:0]    crc_hold_reg;
    logic                          seen_reg;
    logic [RK_W-1:0]               row_idx_reg;
    logic [PW-1:0]                 col_reg;
    logic                          phase_reg;

    // column datapath
    logic [DW-1:0]                 med_reg;
    logic [DW-1:0]                 s_reg;
    logic [drba_pkg::DEN_W-1:0]    den_reg;
    logic [DW-1:0]                 v_reg;
    logic [DW-1:0]                 m_reg;
    logic [drba_pkg::DEN_W-1:0]    rem_reg;
    logic [drba_pkg::FRAC_W-1:0]   u_reg;
    logic [4:0]                    bit_reg;
    logic [drba_pkg::WGT_W-1:0]    t_reg;
    logic [drba_pkg::WGT_W-1:0]    w_reg;
    logic [64:0]                   plo_reg;
    logic [64:0]                   phi_reg;
    logic [ACC_W-1:0]              acc_reg;
    logic [SW_W-1:0]               sumw_reg;
    logic [ACC_W-1:0]              mag_reg;
    logic                          neg_reg;
    logic [SW_W-1:0]               rdiv_reg;
    logic [DW-1:0]                 q_reg;
    logic [ACNT_W-1:0]             acnt_reg;

    // output register
    logic                          out_valid_reg;
    logic [DW-1:0]                 average_reg;
    logic [drba_pkg::COLOUT_W-1:0] column_reg;
    logic [drba_pkg::STAT_W-1:0]   status_reg;
    logic                          last_reg;

    // memories
    logic [DW-1:0]                 store_mem [ST_DEPTH];
    logic [drba_pkg::CRC_W-1:0]    ck_mem [MAX_ROWS];
    logic [DW-1:0]                 store_rd_reg;
    logic [drba_pkg::CRC_W-1:0]    ck_rd_reg;

    logic                          in_acc;
    logic                          elem_acc;
    logic                          fin_acc;
    logic [PW-1:0]                 limit;
    logic                          room;
    logic [PW-1:0]                 pos_inc;
    logic [drba_pkg::CRC_W-1:0]    crc_new;
    logic                          short_row;
    logic                          last_row;
    logic                          last_col;
    logic                          out_free;
    logic                          store_we;
    logic [ST_AW-1:0]              store_wa;
    logic                          store_re;
    logic [ST_AW-1:0]              store_ra;
    logic                          ck_re;
    logic                          ck_we;
    logic                          out_load;
    drba_pkg::drba_sort_cmd_t      sort_cmd;
    logic [DW-1:0]                 sort_data;
    logic                          sort_done;
    logic [DW-1:0]                 sort_median;
    logic [DW-1:0]                 med_s;
    logic [DW-1:0]                 dev;
    logic                          d_ge_den;
    logic [drba_pkg::DEN_W:0]      rem2;
    logic                          div_ge;
    logic [63:0]                   uu;
    logic [65:0]                   tt;
    logic [96:0]                   prod;
    logic [SW_W:0]                 r2;
    logic                          avg_ge;
    logic [DW-1:0]                 avg_val;
    logic [drba_pkg::STAT_W-1:0]   stat_val;

    // handshake
    assign in_stall = (state_reg != drba_pkg::S_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign elem_acc = in_acc && (action == drba_pkg::ACT_SAMPLE);
    assign fin_acc  = in_acc && (action == drba_pkg::ACT_FINISH);
    assign out_free = !out_valid_reg || !out_stall;

    // element intake
    assign limit     = (row_length_reg != '0) ? row_length_reg : COLS_CAP;
    assign room      = pos_reg < limit;
    assign pos_inc   = room ? pos_reg + PW'(1) : pos_reg;
    assign crc_new   = drba_pkg::crc64_update(crc_reg, sample);
    assign short_row = (row_length_reg != '0) && (pos_inc < row_length_reg);
    assign store_we  = elem_acc && room && (rows_kept_reg < ROWS_CAP);
    assign store_wa  = ST_AW'(rows_kept_reg[ROW_AW-1:0]) * COLS_A + ST_AW'(pos_reg);
    assign store_ra  = ST_AW'(row_idx_reg[ROW_AW-1:0]) * COLS_A + ST_AW'(col_reg);

    assign last_row = (row_idx_reg + RK_W'(1)) == rows_kept_reg;
    assign last_col = (col_reg + PW'(1)) == row_length_reg;

    // deviation from the median, median kept sign-biased
    assign med_s    = med_reg ^ drba_pkg::SIGN_BIT;
    assign dev      = ((store_rd_reg ^ drba_pkg::SIGN_BIT) >= med_reg) ? store_rd_reg - med_s
                                                                      : med_s - store_rd_reg;
    assign d_ge_den = {3'b000, dev} >= den_reg;

    // weight arithmetic
    assign rem2   = {rem_reg, 1'b0};
    assign div_ge = rem2 >= {1'b0, den_reg};
    assign uu     = u_reg * u_reg;
    assign tt     = t_reg * t_reg;
    assign prod   = {phi_reg, 32'h0} + {32'h0, plo_reg};

    // final divide step
    assign r2     = {rdiv_reg, mag_reg[ACC_W-1]};
    assign avg_ge = r2 >= {1'b0, sumw_reg};

    // result fields
    assign avg_val  = (sumw_reg == '0) ? '0 : (neg_reg ? '0 - q_reg : q_reg);
    assign stat_val = (sumw_reg == '0) ? drba_pkg::STAT_ZERO_WEIGHT
                    : (dropped_reg ? drba_pkg::STAT_DROPPED : drba_pkg::STAT_OK);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            drba_pkg::S_IDLE:
            begin
                if (elem_acc && row_end && !short_row)
                begin
                    state_next = (rows_kept_reg == '0) ? drba_pkg::S_ROW_DONE
                                                       : drba_pkg::S_SCAN_RD;
                end
                else if (fin_acc)
                begin
                    state_next = (rows_kept_reg == '0) ? drba_pkg::S_EMPTY
                                                       : drba_pkg::S_COL_START;
                end
            end
            drba_pkg::S_SCAN_RD:   state_next = drba_pkg::S_SCAN_CMP;
            drba_pkg::S_SCAN_CMP:
            begin
                state_next = last_row ? drba_pkg::S_ROW_DONE : drba_pkg::S_SCAN_RD;
            end
            drba_pkg::S_ROW_DONE:  state_next = drba_pkg::S_IDLE;
            drba_pkg::S_COL_START: state_next = drba_pkg::S_LOAD_RD;
            drba_pkg::S_LOAD_RD:   state_next = drba_pkg::S_LOAD_WR;
            drba_pkg::S_LOAD_WR:
            begin
                state_next = last_row ? drba_pkg::S_SORT_WAIT : drba_pkg::S_LOAD_RD;
            end
            drba_pkg::S_SORT_WAIT:
            begin
                if (sort_done)
                begin
                    state_next = phase_reg ? drba_pkg::S_DEN : drba_pkg::S_LOAD_RD;
                end
            end
            drba_pkg::S_DEN:       state_next = drba_pkg::S_WGT_RD;
            drba_pkg::S_WGT_RD:    state_next = drba_pkg::S_WGT_CHK;
            drba_pkg::S_WGT_CHK:
            begin
                if (!d_ge_den)
                begin
                    state_next = drba_pkg::S_WGT_DIV;
                end
                else
                begin
                    state_next = last_row ? drba_pkg::S_AVG_PREP : drba_pkg::S_WGT_RD;
                end
            end
            drba_pkg::S_WGT_DIV:
            begin
                if (bit_reg == 5'd31)
                begin
                    state_next = drba_pkg::S_WGT_SQR;
                end
            end
            drba_pkg::S_WGT_SQR:   state_next = drba_pkg::S_WGT_TSQ;
            drba_pkg::S_WGT_TSQ:   state_next = drba_pkg::S_WGT_PLO;
            drba_pkg::S_WGT_PLO:   state_next = drba_pkg::S_WGT_PHI;
            drba_pkg::S_WGT_PHI:   state_next = drba_pkg::S_WGT_ACC;
            drba_pkg::S_WGT_ACC:
            begin
                state_next = last_row ? drba_pkg::S_AVG_PREP : drba_pkg::S_WGT_RD;
            end
            drba_pkg::S_AVG_PREP:
            begin
                state_next = (sumw_reg == '0) ? drba_pkg::S_EMIT : drba_pkg::S_AVG_DIV;
            end
            drba_pkg::S_AVG_DIV:
            begin
                if (acnt_reg == '0)
                begin
                    state_next = drba_pkg::S_EMIT;
                end
            end
            drba_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = last_col ? drba_pkg::S_IDLE : drba_pkg::S_COL_START;
                end
            end
            drba_pkg::S_EMPTY:
            begin
                if (out_free)
                begin
                    state_next = drba_pkg::S_IDLE;
                end
            end
            default: state_next = drba_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        store_re         = 1'b0;
        ck_re            = 1'b0;
        ck_we            = 1'b0;
        out_load         = 1'b0;
        sort_cmd.load_en = 1'b0;
        sort_cmd.start   = 1'b0;
        sort_data        = phase_reg ? dev : store_rd_reg ^ drba_pkg::SIGN_BIT;
        unique case (state_reg)
            drba_pkg::S_SCAN_RD:  ck_re = 1'b1;
            drba_pkg::S_ROW_DONE: ck_we = !seen_reg && (rows_kept_reg < ROWS_CAP);
            drba_pkg::S_LOAD_RD:  store_re = 1'b1;
            drba_pkg::S_WGT_RD:   store_re = 1'b1;
            drba_pkg::S_LOAD_WR:
            begin
                sort_cmd.load_en = 1'b1;
                sort_cmd.start   = last_row;
            end
            drba_pkg::S_EMIT:     out_load = out_free;
            drba_pkg::S_EMPTY:    out_load = out_free;
            default:              store_re = 1'b0;
        endcase
    end

    // sample store
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_mem[store_wa] <= sample;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_re)
        begin
            store_rd_reg <= store_mem[store_ra];
        end
    end

    // row checksum store
    always_ff @(posedge clk)
    begin
        if (ck_we)
        begin
            ck_mem[rows_kept_reg[ROW_AW-1:0]] <= crc_hold_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ck_re)
        begin
            ck_rd_reg <= ck_mem[row_idx_reg[ROW_AW-1:0]];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= drba_pkg::S_IDLE;
            rows_kept_reg  <= '0;
            row_length_reg <= '0;
            pos_reg        <= '0;
            crc_reg        <= drba_pkg::CRC_INIT;
            dropped_reg    <= 1'b0;
            seen_reg       <= 1'b0;
            row_idx_reg    <= '0;
            col_reg        <= '0;
            phase_reg      <= 1'b0;
            bit_reg        <= '0;
            acnt_reg       <= '0;
            acc_reg        <= '0;
            sumw_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                drba_pkg::S_IDLE:
                begin
                    if (elem_acc)
                    begin
                        if (!room)
                        begin
                            dropped_reg <= 1'b1;
                        end
                        if (row_end)
                        begin
                            crc_reg     <= drba_pkg::CRC_INIT;
                            seen_reg    <= 1'b0;
                            row_idx_reg <= '0;
                            if (short_row)
                            begin
                                dropped_reg <= 1'b1;
                                pos_reg     <= '0;
                            end
                            else
                            begin
                                pos_reg <= pos_inc;
                            end
                        end
                        else
                        begin
                            crc_reg <= crc_new;
                            pos_reg <= pos_inc;
                        end
                    end
                    else if (fin_acc)
                    begin
                        if (pos_reg != '0)
                        begin
                            dropped_reg <= 1'b1;
                        end
                        col_reg <= '0;
                    end
                end
                drba_pkg::S_SCAN_CMP:
                begin
                    if (ck_rd_reg == crc_hold_reg)
                    begin
                        seen_reg <= 1'b1;
                    end
                    row_idx_reg <= row_idx_reg + RK_W'(1);
                end
                drba_pkg::S_ROW_DONE:
                begin
                    if (!seen_reg)
                    begin
                        if (rows_kept_reg < ROWS_CAP)
                        begin
                            rows_kept_reg <= rows_kept_reg + RK_W'(1);
                            if (row_length_reg == '0)
                            begin
                                row_length_reg <= pos_reg;
                            end
                        end
                        else
                        begin
                            dropped_reg <= 1'b1;
                        end
                    end
                    pos_reg <= '0;
                end
                drba_pkg::S_COL_START:
                begin
                    row_idx_reg <= '0;
                    phase_reg   <= 1'b0;
                end
                drba_pkg::S_LOAD_WR:
                begin
                    row_idx_reg <= last_row ? '0 : row_idx_reg + RK_W'(1);
                end
                drba_pkg::S_SORT_WAIT:
                begin
                    if (sort_done)
                    begin
                        phase_reg <= 1'b1;
                    end
                end
                drba_pkg::S_DEN:
                begin
                    acc_reg  <= '0;
                    sumw_reg <= '0;
                end
                drba_pkg::S_WGT_CHK:
                begin
                    bit_reg <= '0;
                    if (d_ge_den)
                    begin
                        row_idx_reg <= row_idx_reg + RK_W'(1);
                    end
                end
                drba_pkg::S_WGT_DIV:
                begin
                    bit_reg <= bit_reg + 5'd1;
                end
                drba_pkg::S_WGT_ACC:
                begin
                    acc_reg     <= v_reg[DW-1] ? acc_reg - ACC_W'(prod) : acc_reg + ACC_W'(prod);
                    sumw_reg    <= sumw_reg + SW_W'(w_reg);
                    row_idx_reg <= row_idx_reg + RK_W'(1);
                end
                drba_pkg::S_AVG_PREP:
                begin
                    acnt_reg <= ACNT_W'(ACC_W - 1);
                end
                drba_pkg::S_AVG_DIV:
                begin
                    acnt_reg <= acnt_reg - ACNT_W'(1);
                end
                drba_pkg::S_EMIT:
                begin
                    if (out_free)
                    begin
                        col_reg <= col_reg + PW'(1);
                        if (last_col)
                        begin
                            rows_kept_reg  <= '0;
                            row_length_reg <= '0;
                            pos_reg        <= '0;
                            crc_reg        <= drba_pkg::CRC_INIT;
                            dropped_reg    <= 1'b0;
                        end
                    end
                end
                drba_pkg::S_EMPTY:
                begin
                    if (out_free)
                    begin
                        rows_kept_reg  <= '0;
                        row_length_reg <= '0;
                        pos_reg        <= '0;
                        crc_reg        <= drba_pkg::CRC_INIT;
                        dropped_reg    <= 1'b0;
                    end
                end
                default:
                begin
                    phase_reg <= phase_reg;
                end
            endcase
        end
    end

    // column datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            drba_pkg::S_IDLE:
            begin
                if (elem_acc && row_end)
                begin
                    crc_hold_reg <= ~crc_new;
                end
            end
            drba_pkg::S_SORT_WAIT:
            begin
                if (sort_done)
                begin
                    if (phase_reg)
                    begin
                        s_reg <= sort_median;
                    end
                    else
                    begin
                        med_reg <= sort_median;
                    end
                end
            end
            drba_pkg::S_DEN:
            begin
                den_reg <= {1'b0, s_reg, 2'b00} + {3'b000, s_reg} + drba_pkg::EPS_Q;
            end
            drba_pkg::S_WGT_CHK:
            begin
                v_reg   <= store_rd_reg;
                m_reg   <= store_rd_reg[DW-1] ? '0 - store_rd_reg : store_rd_reg;
                rem_reg <= {3'b000, dev};
                u_reg   <= '0;
            end
            drba_pkg::S_WGT_DIV:
            begin
                rem_reg <= div_ge ? drba_pkg::DEN_W'(rem2 - {1'b0, den_reg})
                                  : rem2[drba_pkg::DEN_W-1:0];
                u_reg   <= {u_reg[drba_pkg::FRAC_W-2:0], div_ge};
            end
            drba_pkg::S_WGT_SQR:
            begin
                t_reg <= drba_pkg::ONE_Q - {1'b0, uu[63:32]};
            end
            drba_pkg::S_WGT_TSQ:
            begin
                w_reg <= tt[64:32];
            end
            drba_pkg::S_WGT_PLO:
            begin
                plo_reg <= m_reg[31:0] * w_reg;
            end
            drba_pkg::S_WGT_PHI:
            begin
                phi_reg <= m_reg[63:32] * w_reg;
            end
            drba_pkg::S_AVG_PREP:
            begin
                neg_reg  <= acc_reg[ACC_W-1];
                mag_reg  <= acc_reg[ACC_W-1] ? '0 - acc_reg : acc_reg;
                rdiv_reg <= '0;
                q_reg    <= '0;
            end
            drba_pkg::S_AVG_DIV:
            begin
                rdiv_reg <= avg_ge ? SW_W'(r2 - {1'b0, sumw_reg}) : SW_W'(r2);
                mag_reg  <= {mag_reg[ACC_W-2:0], 1'b0};
                q_reg    <= {q_reg[DW-2:0], avg_ge};
            end
            drba_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    average_reg <= avg_val;
                    column_reg  <= col_reg[drba_pkg::COLOUT_W-1:0];
                    status_reg  <= stat_val;
                    last_reg    <= last_col;
                end
            end
            drba_pkg::S_EMPTY:
            begin
                if (out_free)
                begin
                    average_reg <= '0;
                    column_reg  <= '0;
                    status_reg  <= drba_pkg::STAT_NO_ROWS;
                    last_reg    <= 1'b1;
                end
            end
            default:
            begin
                v_reg <= v_reg;
            end
        endcase
    end

    drba_sorter #(
        .MAX_ROWS (MAX_ROWS)
    ) u_sorter (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (sort_cmd),
        .load_idx  (row_idx_reg[ROW_AW-1:0]),
        .load_data (sort_data),
        .count     (rows_kept_reg),
        .done      (sort_done),
        .median    (sort_median)
    );

    assign out_valid = out_valid_reg;
    assign average   = average_reg;
    assign column    = column_reg;
    assign status    = status_reg;
    assign last      = last_reg;

    `DRBA_ALWAYS(a_rows_cap, rows_kept_reg <= ROWS_CAP, "kept rows over capacity")
    `DRBA_IMPLIES(a_acc_needs_weight, acc_reg != '0, sumw_reg != '0, "weighted sum without weight")
    `DRBA_IMPLIES(a_div_rem_bound, state_reg == drba_pkg::S_WGT_DIV, rem_reg < den_reg, "divider remainder out of range")

endmodule

`default_nettype wire

@@ rtl/core/drba_sorter.sv @@
`default_nettype none

`include "distinct_row_biweight_average_macros.svh"

module drba_sorter #(
    parameter int MAX_ROWS = drba_pkg::DEF_MAX_ROWS
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire drba_pkg::drba_sort_cmd_t     cmd,
    input  wire logic [ROW_AW-1:0]            load_idx,
    input  wire logic [drba_pkg::DATA_W-1:0]  load_data,
    input  wire logic [RK_W-1:0]              count,
    output logic                              done,
    output logic [drba_pkg::DATA_W-1:0]       median
);

    localparam int RK_W   = $clog2(MAX_ROWS + 1);
    localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    drba_pkg::drba_sort_state_t state_reg, state_next;

    logic [drba_pkg::DATA_W-1:0] mem [MAX_ROWS];
    logic [drba_pkg::DATA_W-1:0] rd_data_reg;
    logic [drba_pkg::DATA_W-1:0] carry_reg;
    logic [drba_pkg::DATA_W-1:0] x_reg;
    logic [drba_pkg::DATA_W-1:0] median_reg;
    logic [RK_W-1:0]             idx_reg;
    logic [RK_W-1:0]             pass_reg;
    logic                        done_reg;

    logic                        wr_en;
    logic [ROW_AW-1:0]           wr_addr;
    logic [drba_pkg::DATA_W-1:0] wr_data;
    logic                        rd_en;
    logic [ROW_AW-1:0]           rd_addr;
    logic                        carry_gt;
    logic [RK_W-1:0]             half;
    logic [RK_W-1:0]             idx_a;
    logic [drba_pkg::DATA_W-1:0] mid;

    // median indexes
    assign half     = count >> 1;
    assign idx_a    = count[0] ? half : half - RK_W'(1);
    assign carry_gt = carry_reg > rd_data_reg;
    assign mid      = (x_reg >> 1) + (rd_data_reg >> 1)
                    + {{(drba_pkg::DATA_W-1){1'b0}}, x_reg[0] & rd_data_reg[0]};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            drba_pkg::SR_IDLE:
            begin
                if (cmd.start)
                begin
                    state_next = (count <= RK_W'(1)) ? drba_pkg::SR_MED_A
                                                     : drba_pkg::SR_FIRST;
                end
            end
            drba_pkg::SR_FIRST: state_next = drba_pkg::SR_LOAD0;
            drba_pkg::SR_LOAD0: state_next = drba_pkg::SR_WALK;
            drba_pkg::SR_WALK:
            begin
                if (idx_reg == count - RK_W'(1))
                begin
                    state_next = drba_pkg::SR_TAIL;
                end
            end
            drba_pkg::SR_TAIL:
            begin
                state_next = (pass_reg == count - RK_W'(2)) ? drba_pkg::SR_MED_A
                                                            : drba_pkg::SR_FIRST;
            end
            drba_pkg::SR_MED_A: state_next = drba_pkg::SR_MED_B;
            drba_pkg::SR_MED_B: state_next = drba_pkg::SR_MED_C;
            drba_pkg::SR_MED_C: state_next = drba_pkg::SR_IDLE;
            default:            state_next = drba_pkg::SR_IDLE;
        endcase
    end

    // memory port control
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = load_idx;
        wr_data = load_data;
        rd_en   = 1'b0;
        rd_addr = '0;
        unique case (state_reg)
            drba_pkg::SR_IDLE:
            begin
                wr_en = cmd.load_en;
            end
            drba_pkg::SR_FIRST:
            begin
                rd_en = 1'b1;
            end
            drba_pkg::SR_LOAD0:
            begin
                rd_en   = 1'b1;
                rd_addr = ROW_AW'(1);
            end
            drba_pkg::SR_WALK:
            begin
                rd_en   = 1'b1;
                rd_addr = ROW_AW'(idx_reg + RK_W'(1));
                wr_en   = 1'b1;
                wr_addr = ROW_AW'(idx_reg - RK_W'(1));
                wr_data = carry_gt ? rd_data_reg : carry_reg;
            end
            drba_pkg::SR_TAIL:
            begin
                wr_en   = 1'b1;
                wr_addr = ROW_AW'(count - RK_W'(1));
                wr_data = carry_reg;
            end
            drba_pkg::SR_MED_A:
            begin
                rd_en   = 1'b1;
                rd_addr = ROW_AW'(idx_a);
            end
            drba_pkg::SR_MED_B:
            begin
                rd_en   = 1'b1;
                rd_addr = ROW_AW'(half);
            end
            drba_pkg::SR_MED_C:
            begin
                rd_en = 1'b0;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // scratch memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= drba_pkg::SR_IDLE;
            idx_reg   <= '0;
            pass_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == drba_pkg::SR_MED_C);
            unique case (state_reg)
                drba_pkg::SR_IDLE:  pass_reg <= '0;
                drba_pkg::SR_LOAD0: idx_reg  <= RK_W'(1);
                drba_pkg::SR_WALK:  idx_reg  <= idx_reg + RK_W'(1);
                drba_pkg::SR_TAIL:  pass_reg <= pass_reg + RK_W'(1);
                default:            idx_reg  <= idx_reg;
            endcase
        end
    end

    // bubble pass carry and median capture
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            drba_pkg::SR_LOAD0: carry_reg <= rd_data_reg;
            drba_pkg::SR_WALK:
            begin
                if (!carry_gt)
                begin
                    carry_reg <= rd_data_reg;
                end
            end
            drba_pkg::SR_MED_B: x_reg <= rd_data_reg;
            drba_pkg::SR_MED_C: median_reg <= count[0] ? rd_data_reg : mid;
            default:            carry_reg <= carry_reg;
        endcase
    end

    assign done   = done_reg;
    assign median = median_reg;

    `DRBA_IMPLIES(a_start_when_idle, cmd.start, state_reg == drba_pkg::SR_IDLE, "sort start while busy")
    `DRBA_NEXT(a_done_single, done_reg, !done_reg, "sort done longer than one cycle")
    `DRBA_IMPLIES(a_walk_in_range, state_reg == drba_pkg::SR_WALK, idx_reg < count, "walk past end")

endmodule

`default_nettype wire
